[design/spag_pkg.sv]
// Shared types and constants for the strided patch read address generator.
// Used by every module of the block; depends on nothing.
package spag_pkg;

  localparam int ADDR_BITS_DEF = 48;

  localparam int ELEM_W   = 4;
  localparam int EXT_W    = 16;
  localparam int PFAST_W  = 12;
  localparam int PROW_W   = 4;
  localparam int OFFS_W   = 48;
  localparam int COUNT_W  = 15;
  localparam int TILE_W   = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ELEM_BYTES  = 3'd0,
    REG_EXTENT_FAST = 3'd1,
    REG_EXTENT_MID  = 3'd2,
    REG_EXTENT_SLOW = 3'd3,
    REG_PATCH_FAST  = 3'd4,
    REG_PATCH_MID   = 3'd5,
    REG_PATCH_SLOW  = 3'd6,
    REG_BASE_OFFSET = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [ELEM_W-1:0]  elem_bytes;
    logic [EXT_W-1:0]   extent_fast;
    logic [EXT_W-1:0]   extent_mid;
    logic [EXT_W-1:0]   extent_slow;
    logic [PFAST_W-1:0] patch_fast;
    logic [PROW_W-1:0]  patch_mid;
    logic [PROW_W-1:0]  patch_slow;
    logic [OFFS_W-1:0]  base_offset;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    elem_bytes:  4'd4,
    extent_fast: 16'd1,
    extent_mid:  16'd1,
    extent_slow: 16'd1,
    patch_fast:  12'd1,
    patch_mid:   4'd1,
    patch_slow:  4'd1,
    base_offset: 48'd0
  };

  typedef struct packed {
    logic [TILE_W-1:0] q_index;
    logic [TILE_W-1:0] tile_fast;
    logic [TILE_W-1:0] tile_mid;
    logic [TILE_W-1:0] tile_slow;
  } in_t;

  typedef struct packed {
    logic [OFFS_W-1:0]  byte_offset;
    logic [COUNT_W-1:0] byte_count;
    logic               last_row;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_MUL4,
    ST_SEED,
    ST_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic mul1;
    logic mul2;
    logic mul3;
    logic mul4;
    logic seed;
    logic emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic rows_zero;
    logic last_row;
    logic out_hold;
  } sts_t;

endpackage

[design/strided_patch_read_address_generator_unit.sv]
// Top level of the strided patch read address generator.
// Depends on spag_pkg, spag_cfg, spag_ctrl and spag_dp.
//
// Usage:
//   Registers are written through cfg_we/cfg_index/cfg_wdata while the block
//   is idle. Each request on the in_ channel names a q index and a patch
//   position per spatial dimension; the out_ channel returns one row burst
//   (byte offset, byte count, last flag) per contiguous row of the patch,
//   slow row index outer, mid row index inner, last_row set on the final one.
//   Sequence: once a request is accepted, four product steps on the
//   multipliers plus a seed step build the origin, then one burst per
//   cycle follows from the row adder while out_ready stays high.
//   A request has R rows, 1 to 64. A request with zero patch rows is
//   accepted and dropped without leaving the idle state.
//   in_ready rises as soon as the final burst sits in the output register,
//   so the next request overlaps the wait for that burst to be taken.
//   Stall: a low out_ready holds the output register and the row walk.
//   Reset: synchronous, active low; registers return to their defaults and
//   any request in flight is dropped.
module strided_patch_read_address_generator_unit #(
  parameter int ADDR_BITS = spag_pkg::ADDR_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  spag_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output spag_pkg::out_t                    out_data,
  input  logic                              cfg_we,
  input  logic [spag_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [spag_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  spag_pkg::cfg_t cfg;
  spag_pkg::cmd_t cmd;
  spag_pkg::sts_t sts;

  spag_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  spag_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  spag_dp #(
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[design/spag_cfg.sv]
// Configuration register file of the strided patch read address generator.
// Depends on spag_pkg for the register layout and reset values.
module spag_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [spag_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [spag_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output spag_pkg::cfg_t                    cfg
);

  spag_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= spag_pkg::CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        spag_pkg::REG_ELEM_BYTES:  cfg_r.elem_bytes  <= cfg_wdata[spag_pkg::ELEM_W-1:0];
        spag_pkg::REG_EXTENT_FAST: cfg_r.extent_fast <= cfg_wdata[spag_pkg::EXT_W-1:0];
        spag_pkg::REG_EXTENT_MID:  cfg_r.extent_mid  <= cfg_wdata[spag_pkg::EXT_W-1:0];
        spag_pkg::REG_EXTENT_SLOW: cfg_r.extent_slow <= cfg_wdata[spag_pkg::EXT_W-1:0];
        spag_pkg::REG_PATCH_FAST:  cfg_r.patch_fast  <= cfg_wdata[spag_pkg::PFAST_W-1:0];
        spag_pkg::REG_PATCH_MID:   cfg_r.patch_mid   <= cfg_wdata[spag_pkg::PROW_W-1:0];
        spag_pkg::REG_PATCH_SLOW:  cfg_r.patch_slow  <= cfg_wdata[spag_pkg::PROW_W-1:0];
        spag_pkg::REG_BASE_OFFSET: cfg_r.base_offset <= cfg_wdata[spag_pkg::OFFS_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[design/spag_dp.sv]
// Datapath: stride and origin products, row address walk and output register.
// Depends on spag_pkg; driven by spag_ctrl through cmd_t, reports through sts_t.
module spag_dp #(
  parameter int ADDR_BITS = spag_pkg::ADDR_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  spag_pkg::cfg_t cfg,
  input  spag_pkg::in_t  in_data,
  input  spag_pkg::cmd_t cmd,
  output spag_pkg::sts_t sts,
  input  logic           out_ready,
  output logic           out_valid,
  output spag_pkg::out_t out_data
);

  localparam int AW     = ADDR_BITS;
  localparam int PF_W   = spag_pkg::TILE_W + spag_pkg::PFAST_W;
  localparam int PR_W   = spag_pkg::TILE_W + spag_pkg::PROW_W;
  localparam int CNT_FW = spag_pkg::ELEM_W + spag_pkg::PFAST_W;

  spag_pkg::in_t  in_r;
  logic [PF_W-1:0] prod_f_r;
  logic [PR_W-1:0] prod_m_r;
  logic [PR_W-1:0] prod_s_r;
  logic [AW-1:0]   s_mid_r;
  logic [AW-1:0]   s_slow_r;
  logic [AW-1:0]   s_q_r;
  logic [AW-1:0]   term_f_r;
  logic [AW-1:0]   term_m_r;
  logic [AW-1:0]   term_s_r;
  logic [AW-1:0]   term_q_r;
  logic [AW-1:0]   acc_r;
  logic [AW-1:0]   plane_r;
  logic [AW-1:0]   row_r;
  logic [2:0]      i_r;
  logic [2:0]      j_r;
  spag_pkg::out_t  out_r;
  logic            out_valid_r;

  logic [spag_pkg::PROW_W-1:0]  rows_mid;
  logic [spag_pkg::PROW_W-1:0]  rows_slow;
  logic [2:0]                   last_j;
  logic [2:0]                   last_i;
  logic                         row_last;
  logic                         mid_wrap;
  logic [CNT_FW-1:0]            count_full;
  logic [spag_pkg::COUNT_W-1:0] count_sat;
  logic [AW-1:0]                next_plane;

  // Row counts above eight are taken as eight
  always_comb begin
    rows_mid   = (cfg.patch_mid  > 4'd8) ? 4'd8 : cfg.patch_mid;
    rows_slow  = (cfg.patch_slow > 4'd8) ? 4'd8 : cfg.patch_slow;
    last_j     = 3'(rows_mid  - 4'd1);
    last_i     = 3'(rows_slow - 4'd1);
    mid_wrap   = (j_r == last_j);
    row_last   = mid_wrap && (i_r == last_i);
    count_full = CNT_FW'(cfg.elem_bytes) * CNT_FW'(cfg.patch_fast);
    count_sat  = count_full[CNT_FW-1] ? spag_pkg::COUNT_MAX
                                      : count_full[spag_pkg::COUNT_W-1:0];
    next_plane = plane_r + s_slow_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_r <= in_data;
    end
    if (cmd.mul1) begin
      s_mid_r  <= AW'(cfg.elem_bytes) * AW'(cfg.extent_fast);
      prod_f_r <= PF_W'(in_r.tile_fast) * PF_W'(cfg.patch_fast);
      prod_m_r <= PR_W'(in_r.tile_mid) * PR_W'(cfg.patch_mid);
      prod_s_r <= PR_W'(in_r.tile_slow) * PR_W'(cfg.patch_slow);
    end
    if (cmd.mul2) begin
      s_slow_r <= s_mid_r * AW'(cfg.extent_mid);
      term_f_r <= AW'(cfg.elem_bytes) * AW'(prod_f_r);
      term_m_r <= s_mid_r * AW'(prod_m_r);
    end
    if (cmd.mul3) begin
      s_q_r    <= s_slow_r * AW'(cfg.extent_slow);
      term_s_r <= s_slow_r * AW'(prod_s_r);
      acc_r    <= AW'(cfg.base_offset) + term_f_r + term_m_r;
    end
    if (cmd.mul4) begin
      term_q_r <= s_q_r * AW'(in_r.q_index);
      acc_r    <= acc_r + term_s_r;
    end
    if (cmd.seed) begin
      row_r   <= acc_r + term_q_r;
      plane_r <= acc_r + term_q_r;
      i_r     <= 3'd0;
      j_r     <= 3'd0;
    end else if (cmd.emit) begin
      out_r.byte_offset <= spag_pkg::OFFS_W'(row_r);
      out_r.byte_count  <= count_sat;
      out_r.last_row    <= row_last;
      // Advance to the next mid row, or step to the next slow plane
      if (mid_wrap) begin
        j_r     <= 3'd0;
        i_r     <= i_r + 3'd1;
        plane_r <= next_plane;
        row_r   <= next_plane;
      end else begin
        j_r   <= j_r + 3'd1;
        row_r <= row_r + s_mid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.rows_zero = (cfg.patch_mid == '0) || (cfg.patch_slow == '0);
  assign sts.last_row  = row_last;
  assign sts.out_hold  = out_valid_r && !out_ready;
  assign out_valid     = out_valid_r;
  assign out_data      = out_r;

endmodule

[design/spag_ctrl.sv]
// Controller: sequences the product steps and the row bursts of one request.
// Depends on spag_pkg; talks to spag_dp through cmd_t and sts_t only.
module spag_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  spag_pkg::sts_t sts,
  output spag_pkg::cmd_t cmd
);

  spag_pkg::state_t state_r;
  spag_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spag_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      spag_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          // Drop a request whose patch has no rows
          if (!sts.rows_zero) begin
            state_nxt = spag_pkg::ST_MUL1;
          end
        end
      end
      spag_pkg::ST_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = spag_pkg::ST_MUL2;
      end
      spag_pkg::ST_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = spag_pkg::ST_MUL3;
      end
      spag_pkg::ST_MUL3: begin
        cmd.mul3  = 1'b1;
        state_nxt = spag_pkg::ST_MUL4;
      end
      spag_pkg::ST_MUL4: begin
        cmd.mul4  = 1'b1;
        state_nxt = spag_pkg::ST_SEED;
      end
      spag_pkg::ST_SEED: begin
        cmd.seed  = 1'b1;
        state_nxt = spag_pkg::ST_EMIT;
      end
      spag_pkg::ST_EMIT: begin
        if (!sts.out_hold) begin
          cmd.emit = 1'b1;
          if (sts.last_row) begin
            state_nxt = spag_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = spag_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[design/spag_chk.sv]
// Port-level checker for the strided patch read address generator.
// Depends on spag_pkg; bound to the top level at the end of this file.
module spag_chk (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input spag_pkg::out_t out_data
);

  // Stalled burst holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled burst changed or dropped");

  // Nothing left over from before reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("burst valid right after reset");

  // More rows pending: no new request taken
  a_busy_mid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_row |-> !in_ready)
    else $error("request taken while rows still pending");

  // Origin takes several steps: no burst straight after acceptance
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("burst appeared one cycle after request");

endmodule

bind strided_patch_read_address_generator_unit spag_chk u_spag_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

[tb/strided_patch_read_address_generator_unit_test.sv]
// Self-checking bench for strided_patch_read_address_generator_unit.
// Predicts every row burst from a local copy of the registers; needs spag_pkg and the RTL.
module strided_patch_read_address_generator_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN     = 100;
  localparam int CYCLE_CAP = 3_000_000;
  localparam int RAND_SETS = 10;
  localparam int RAND_REQS = 34;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  spag_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  spag_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic [spag_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [spag_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  spag_pkg::cfg_t shadow = spag_pkg::CFG_RESET;
  spag_pkg::in_t pending[$];
  spag_pkg::out_t burst_q[$];
  int unsigned queued = 0;
  int unsigned accepted = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned send_gap = 0;
  int unsigned send_calm = 0;
  int unsigned take_stall = 0;
  int unsigned take_calm = 0;

  strided_patch_read_address_generator_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Mostly random waits, with occasional runs of back-to-back traffic.
  function automatic int unsigned pick_wait(inout int unsigned calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  // Expected row bursts of one request under the current register settings.
  function automatic void plan_bursts(spag_pkg::in_t req);
    logic [63:0] st_fast, st_mid, st_slow, st_q, origin, addr, bytes;
    int unsigned n_mid, n_slow;
    spag_pkg::out_t b;
    st_fast = 64'(shadow.elem_bytes);
    st_mid  = st_fast * 64'(shadow.extent_fast);
    st_slow = st_mid * 64'(shadow.extent_mid);
    st_q    = st_slow * 64'(shadow.extent_slow);
    bytes   = 64'(shadow.elem_bytes) * 64'(shadow.patch_fast);
    n_mid   = (shadow.patch_mid > 8) ? 8 : shadow.patch_mid;
    n_slow  = (shadow.patch_slow > 8) ? 8 : shadow.patch_slow;
    if (n_mid == 0 || n_slow == 0) return;
    // Tile steps use the raw patch registers, not the clamped row counts.
    origin = 64'(shadow.base_offset)
           + st_fast * 64'(req.tile_fast) * 64'(shadow.patch_fast)
           + st_mid * 64'(req.tile_mid) * 64'(shadow.patch_mid)
           + st_slow * 64'(req.tile_slow) * 64'(shadow.patch_slow)
           + st_q * 64'(req.q_index);
    for (int i = 0; i < n_slow; i++) begin
      for (int j = 0; j < n_mid; j++) begin
        addr = origin + 64'(i) * st_slow + 64'(j) * st_mid;
        b.byte_offset = addr[spag_pkg::OFFS_W-1:0];
        b.byte_count = (bytes > 64'(spag_pkg::COUNT_MAX)) ? spag_pkg::COUNT_MAX
                                                          : bytes[spag_pkg::COUNT_W-1:0];
        b.last_row = (i == n_slow - 1) && (j == n_mid - 1);
        burst_q.push_back(b);
      end
    end
  endfunction

  function automatic spag_pkg::cfg_t random_setup();
    spag_pkg::cfg_t c;
    c.elem_bytes  = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8));
    c.extent_fast = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 64));
    c.extent_mid  = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 64));
    c.extent_slow = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 64));
    c.patch_fast  = $urandom_range(0, 1) ? 12'($urandom) : 12'($urandom_range(1, 16));
    c.patch_mid   = ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8));
    c.patch_slow  = ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8));
    c.base_offset = {16'($urandom), 32'($urandom)};
    return c;
  endfunction

  // Request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid || in_ready) begin
      if (send_gap != 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending.size() != 0) begin
        in_data  <= pending.pop_front();
        in_valid <= 1'b1;
        send_gap <= pick_wait(send_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Burst receiver: stall a random number of cycles after each taken burst
  always @(posedge clk) begin
    int unsigned wait_n;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      take_stall <= 0;
    end else if (out_valid && out_ready) begin
      wait_n = pick_wait(take_calm);
      take_stall <= wait_n;
      out_ready  <= (wait_n == 0);
    end else if (take_stall != 0) begin
      out_ready  <= (take_stall == 1);
      take_stall <= take_stall - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Predict on accepted requests, compare accepted bursts
  always @(posedge clk) begin
    spag_pkg::out_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        plan_bursts(in_data);
        accepted++;
      end
      if (out_valid && out_ready) begin
        if (burst_q.size() == 0) begin
          $error("unexpected burst: byte_offset %h byte_count %0d last_row %0b",
                 out_data.byte_offset, out_data.byte_count, out_data.last_row);
          errors++;
        end else begin
          want = burst_q.pop_front();
          if (out_data.byte_offset !== want.byte_offset) begin
            $error("byte_offset: expected %h, got %h", want.byte_offset, out_data.byte_offset);
            errors++;
          end
          if (out_data.byte_count !== want.byte_count) begin
            $error("byte_count: expected %0d, got %0d", want.byte_count, out_data.byte_count);
            errors++;
          end
          if (out_data.last_row !== want.last_row) begin
            $error("last_row: expected %0b, got %0b", want.last_row, out_data.last_row);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_reg(spag_pkg::reg_idx_t idx, logic [spag_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
  endtask

  task automatic load_setup(spag_pkg::cfg_t c);
    write_reg(spag_pkg::REG_ELEM_BYTES, spag_pkg::CFG_DATA_W'(c.elem_bytes));
    write_reg(spag_pkg::REG_EXTENT_FAST, spag_pkg::CFG_DATA_W'(c.extent_fast));
    write_reg(spag_pkg::REG_EXTENT_MID, spag_pkg::CFG_DATA_W'(c.extent_mid));
    write_reg(spag_pkg::REG_EXTENT_SLOW, spag_pkg::CFG_DATA_W'(c.extent_slow));
    write_reg(spag_pkg::REG_PATCH_FAST, spag_pkg::CFG_DATA_W'(c.patch_fast));
    write_reg(spag_pkg::REG_PATCH_MID, spag_pkg::CFG_DATA_W'(c.patch_mid));
    write_reg(spag_pkg::REG_PATCH_SLOW, spag_pkg::CFG_DATA_W'(c.patch_slow));
    write_reg(spag_pkg::REG_BASE_OFFSET, spag_pkg::CFG_DATA_W'(c.base_offset));
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow = c;
  endtask

  task automatic queue_req(spag_pkg::in_t r);
    @(negedge clk);
    pending.push_back(r);
    queued++;
  endtask

  task automatic wait_quiet();
    @(negedge clk);
    while (!(accepted == queued && burst_q.size() == 0)) @(negedge clk);
  endtask

  // Let dropped zero-row requests clear before touching registers
  task automatic settle();
    wait_quiet();
    repeat (DRAIN) @(negedge clk);
  endtask

  initial begin
    spag_pkg::cfg_t c;
    spag_pkg::in_t r;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset defaults
    queue_req(spag_pkg::in_t'{16'h0000, 16'h0000, 16'h0000, 16'h0000});
    queue_req(spag_pkg::in_t'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    queue_req(spag_pkg::in_t'{16'h0001, 16'h0002, 16'h0003, 16'h0004});
    settle();

    // Largest legal setup, base at the top so offsets wrap
    c = '{4'd8, 16'hFFFF, 16'hFFFF, 16'hFFFF, 12'hFFF, 4'd8, 4'd8, 48'hFFFF_FFFF_FFFF};
    load_setup(c);
    queue_req(spag_pkg::in_t'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    queue_req(spag_pkg::in_t'{16'h0000, 16'h0000, 16'h0000, 16'h0000});
    queue_req(spag_pkg::in_t'{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555});
    settle();

    // Saturated byte count, zero extents, row counts above eight
    c = '{4'd15, 16'd0, 16'd0, 16'd0, 12'hFFF, 4'd15, 4'd9, 48'd0};
    load_setup(c);
    queue_req(spag_pkg::in_t'{16'h1234, 16'hFFFF, 16'h0001, 16'h8000});
    queue_req(spag_pkg::in_t'{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF});
    settle();

    // Zero mid rows: requests produce nothing
    c = '{4'd0, 16'd1, 16'd1, 16'd1, 12'd0, 4'd0, 4'd4, 48'h0000_0000_1000};
    load_setup(c);
    queue_req(spag_pkg::in_t'{16'h00FF, 16'h0F0F, 16'hF0F0, 16'hFF00});
    queue_req(spag_pkg::in_t'{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000});
    settle();

    // Zero slow rows
    c = '{4'd1, 16'd2, 16'd3, 16'd4, 12'd1, 4'd1, 4'd0, 48'h8000_0000_0000};
    load_setup(c);
    queue_req(spag_pkg::in_t'{16'h0003, 16'h0002, 16'h0001, 16'h0000});
    queue_req(spag_pkg::in_t'{16'h8000, 16'h4000, 16'h2000, 16'h1000});
    settle();

    // Zero element size: zero byte count and zero strides
    c = '{4'd0, 16'd7, 16'd9, 16'd11, 12'd5, 4'd2, 4'd2, 48'h1234_5678_9ABC};
    load_setup(c);
    queue_req(spag_pkg::in_t'{16'h0010, 16'h0020, 16'h0030, 16'h0040});
    queue_req(spag_pkg::in_t'{16'hFFFE, 16'hFFFD, 16'hFFFB, 16'hFFF7});
    settle();

    for (int s = 0; s < RAND_SETS; s++) begin
      load_setup(random_setup());
      for (int k = 0; k < RAND_REQS; k++) begin
        // Hold off the sender until the block has drained
        if (k == RAND_REQS / 2) wait_quiet();
        r = spag_pkg::in_t'({$urandom, $urandom});
        queue_req(r);
      end
      settle();
    end

    if (errors == 0 && burst_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
